// ===== sv/assert_macros.svh =====
// Assertion macros for the estimator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OSPE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OSPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OSPE_ASSERT(lbl, clk, rst, prop, msg)
`define OSPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/ospe_pkg.sv =====
// Types and constants of the pilot based SNR estimator
`timescale 1ns / 1ps
package ospe_pkg;
   localparam int CFG_SC_BITS    = 12;
   localparam int CFG_SP_BITS    = 12;
   localparam int CFG_DC_BITS    = 11;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUBCARRIERS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PILOT_SPACING = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DC_NULL_WIDTH = 2'd2;

   localparam logic [CFG_SC_BITS-1:0] RESET_SUBCARRIERS   = 12'd64;
   localparam logic [CFG_SP_BITS-1:0] RESET_PILOT_SPACING = 12'd4;
   localparam logic [CFG_DC_BITS-1:0] RESET_DC_NULL_WIDTH = 11'd2;

   localparam int COUNT_BITS = 13;
   localparam int CMP_BITS   = 14;
   localparam int MOD_BITS   = 12;
   localparam int PROD_BITS  = CFG_SP_BITS + COUNT_BITS;

   localparam int SNR_BITS     = 32;
   localparam int NOISE_BITS   = 39;
   localparam int PMEAN_BITS   = 40;
   localparam int STATUS_BITS  = 2;
   localparam int DIV_DEN_BITS = NOISE_BITS + CFG_SP_BITS;

   localparam logic [SNR_BITS-1:0] SNR_MAX = 32'h7FFF_FFFF;
   localparam logic [SNR_BITS-1:0] SNR_MIN = 32'h8000_0000;

   localparam logic [STATUS_BITS-1:0] ST_VALID      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOISE_ZERO = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_INVALID    = 2'd2;

   typedef struct packed {
      logic [CFG_SP_BITS-1:0] spacing;
      logic [COUNT_BITS-1:0]  count;
      logic [CFG_DC_BITS-1:0] dc;
   } vec_cfg_type;

   typedef enum logic {
      FR_SYNC,
      FR_RUN
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_PREP,
      BK_DIV_K,
      BK_MUL_D,
      BK_CHK_D,
      BK_DIV_NOISE,
      BK_DIV_PM,
      BK_MUL_S,
      BK_SNR_START,
      BK_DIV_SNR,
      BK_OUT
   } back_state_type;
endpackage

// ===== sv/ospe_if.sv =====
// Sample and result channel interfaces of the estimator
`timescale 1ns / 1ps
interface ospe_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_re;
   logic signed [SAMPLE_BITS-1:0] sample_im;
   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

interface ospe_rsp_if import ospe_pkg::*; ;
   logic                          valid;
   logic                          ready;
   logic signed [SNR_BITS-1:0]    snr_ratio;
   logic [NOISE_BITS-1:0]         noise_power;
   logic [STATUS_BITS-1:0]        status;
   modport source (output valid, output snr_ratio, output noise_power, output status,
                   input ready);
   modport sink (input valid, input snr_ratio, input noise_power, input status,
                 output ready);
endinterface

// ===== sv/ofdm_pilot_snr_estimator.sv =====
// Top level of the OFDM pilot based SNR estimator
`timescale 1ns / 1ps
// Subcarrier samples are taken at one per cycle while the result queue has room;
// each sample is squared, classed as pilot, null or guard bin and accumulated.
// After the last bin of a vector its sums go to a two entry queue, and the back
// end works the vector out with one shared restoring divider, one quotient bit a
// cycle. Up to four divisions of NUM_BITS (56 by default) quotient bits run per
// vector, and the back end takes the next vector from the queue only once the
// result of the last one has been taken.
// After reset and after every register write the front end realigns the pilot
// phase before it takes a sample. No memory needs clearing.
module ofdm_pilot_snr_estimator import ospe_pkg::*; #(
   parameter int MAX_SUBCARRIERS = 2048,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   ospe_req_if.sink                  req_bus,
   ospe_rsp_if.source                rsp_bus,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int SUM_BITS      = 2 * SAMPLE_BITS + $clog2(MAX_SUBCARRIERS);
   localparam int NUM_BITS      = (SUM_BITS + 8 > PMEAN_BITS + 16) ? SUM_BITS + 8 :
                                                                     PMEAN_BITS + 16;
   localparam int FIFO_DEPTH    = 2;
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int CFG_BITS      = $bits(vec_cfg_type);
   localparam int FIFO_WIDTH    = 2 * SUM_BITS + CFG_BITS;

   logic                     push, pop, empty;
   logic [FIFO_CNT_BITS-1:0] count;
   logic [SUM_BITS-1:0]      pilot_total, null_total;
   vec_cfg_type              push_cfg, pop_cfg;
   logic [FIFO_WIDTH-1:0]    wr_data, rd_data;

   ospe_front #(
      .MAX_SUBCARRIERS (MAX_SUBCARRIERS),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .SUM_BITS        (SUM_BITS),
      .FIFO_DEPTH      (FIFO_DEPTH),
      .FIFO_CNT_BITS   (FIFO_CNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req         (req_bus),
      .fifo_count  (count),
      .push        (push),
      .pilot_total (pilot_total),
      .null_total  (null_total),
      .push_cfg    (push_cfg)
   );

   assign wr_data = {pilot_total, null_total, push_cfg};

   ospe_fifo #(
      .WIDTH    (FIFO_WIDTH),
      .DEPTH    (FIFO_DEPTH),
      .CNT_BITS (FIFO_CNT_BITS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_data),
      .pop     (pop),
      .rd_data (rd_data),
      .empty   (empty),
      .count   (count)
   );

   assign pop_cfg = rd_data[CFG_BITS-1:0];

   ospe_back #(
      .SUM_BITS (SUM_BITS),
      .NUM_BITS (NUM_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (empty),
      .fifo_pilot (rd_data[FIFO_WIDTH-1:SUM_BITS+CFG_BITS]),
      .fifo_null  (rd_data[SUM_BITS+CFG_BITS-1:CFG_BITS]),
      .fifo_cfg   (pop_cfg),
      .fifo_pop   (pop),
      .rsp        (rsp_bus)
   );
endmodule

// ===== sv/ospe_fifo.sv =====
// Short queue of finished vector sums between front and back
`timescale 1ns / 1ps
module ospe_fifo import ospe_pkg::*; #(
   parameter int WIDTH    = 8,
   parameter int DEPTH    = 2,
   parameter int CNT_BITS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    rd_data,
   output logic                empty,
   output logic [CNT_BITS-1:0] count
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;
endmodule

// ===== sv/ospe_front.sv =====
// Front end: configuration, bin classification and power accumulation
`timescale 1ns / 1ps
module ospe_front import ospe_pkg::*; #(
   parameter int MAX_SUBCARRIERS = 2048,
   parameter int SAMPLE_BITS     = 16,
   parameter int SUM_BITS        = 43,
   parameter int FIFO_DEPTH      = 2,
   parameter int FIFO_CNT_BITS   = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   ospe_req_if.sink                  req,
   input  logic [FIFO_CNT_BITS-1:0]  fifo_count,
   output logic                      push,
   output logic [SUM_BITS-1:0]       pilot_total,
   output logic [SUM_BITS-1:0]       null_total,
   output vec_cfg_type               push_cfg
);
   localparam int IDX_BITS = $clog2(MAX_SUBCARRIERS);
   localparam int PW_BITS  = 2 * SAMPLE_BITS;
   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_SUBCARRIERS);
   localparam logic [3:0] SYNC_LAST = 4'(MOD_BITS - 1);

   function automatic logic [MOD_BITS-1:0] mod_step(input logic [MOD_BITS-1:0] rem,
                                                    input logic b,
                                                    input logic [MOD_BITS-1:0] d);
      logic [MOD_BITS:0] t;
      t = {rem, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[MOD_BITS-1:0];
   endfunction

   front_state_type        state_ff, state_in;
   logic [3:0]             sync_cnt_ff, sync_cnt_in;
   logic [CFG_SC_BITS-1:0] sc_ff, sc_in;
   logic [CFG_SP_BITS-1:0] sp_ff, sp_in;
   logic [CFG_DC_BITS-1:0] dc_ff, dc_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [MOD_BITS-1:0]    ph_ff, ph_in, offm_ff, offm_in;

   logic                   b_valid_ff, b_valid_in;
   logic                   b_pilot_ff, b_kept_ff, b_last_ff;
   logic [PW_BITS-1:0]     b_sqre_ff, b_sqim_ff;
   vec_cfg_type            b_cfg_ff;
   logic [SUM_BITS-1:0]    pilot_sum_ff, pilot_sum_in, null_sum_ff, null_sum_in;

   logic [COUNT_BITS-1:0]  count;
   logic [CMP_BITS-1:0]    i_c, e_c, h_c, n_c;
   logic                   lower, upper, last, pilot, accept, pend;
   logic [MOD_BITS-1:0]    off12, i12, upt;
   logic [MOD_BITS:0]      ph_inc;
   logic signed [SAMPLE_BITS-1:0] re_s, im_s;
   logic signed [PW_BITS-1:0]     sqre_s, sqim_s;
   logic [PW_BITS-1:0]     pw;
   logic [FIFO_CNT_BITS:0] slots;

   assign count = (sc_ff == '0) ? COUNT_BITS'(1) :
                  (({1'b0, sc_ff} > MAX_COUNT) ? MAX_COUNT : {1'b0, sc_ff});
   assign i_c   = CMP_BITS'(idx_ff);
   assign e_c   = CMP_BITS'(dc_ff[CFG_DC_BITS-1:1]);
   assign n_c   = CMP_BITS'(count);
   assign h_c   = CMP_BITS'(count[COUNT_BITS-1:1]);
   assign lower = (i_c >= e_c) && (i_c < h_c);
   assign upper = (i_c >= h_c) && ((i_c + e_c + 1'b1) <= n_c);
   assign last  = (i_c + 1'b1) >= n_c;
   assign upt   = (offm_ff == '0) ? '0 : sp_ff - offm_ff;
   assign pilot = (sp_ff != '0) && (lower ? (ph_ff == offm_ff) : (ph_ff == upt));
   assign ph_inc = {1'b0, ph_ff} + 1'b1;
   assign off12 = {1'b0, sp_ff[CFG_SP_BITS-1:1]} + MOD_BITS'(dc_ff[CFG_DC_BITS-1:1]);
   assign i12   = MOD_BITS'(idx_ff);

   assign re_s   = req.sample_re;
   assign im_s   = req.sample_im;
   assign sqre_s = re_s * re_s;
   assign sqim_s = im_s * im_s;

   assign pend   = b_valid_ff && b_last_ff;
   assign slots  = {1'b0, fifo_count} + (FIFO_CNT_BITS + 1)'(pend);
   assign accept = req.valid && req.ready;

   always_comb begin
      sc_in = sc_ff;
      sp_in = sp_ff;
      dc_in = dc_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SUBCARRIERS:   sc_in = csr_wdata;
            CSR_PILOT_SPACING: sp_in = csr_wdata;
            CSR_DC_NULL_WIDTH: dc_in = csr_wdata[CFG_DC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      sync_cnt_in = sync_cnt_ff;
      idx_in      = idx_ff;
      ph_in       = ph_ff;
      offm_in     = offm_ff;
      req.ready   = 1'b0;
      unique case (state_ff)
         FR_SYNC: begin
            ph_in       = mod_step(ph_ff, i12[sync_cnt_ff], sp_ff);
            offm_in     = mod_step(offm_ff, off12[sync_cnt_ff], sp_ff);
            sync_cnt_in = sync_cnt_ff - 1'b1;
            if (sync_cnt_ff == '0) begin
               state_in = FR_RUN;
            end
         end
         FR_RUN: begin
            req.ready = (slots < (FIFO_CNT_BITS + 1)'(FIFO_DEPTH));
            if (accept) begin
               if (last) begin
                  idx_in = '0;
                  ph_in  = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  ph_in  = (ph_inc == {1'b0, sp_ff}) ? '0 : ph_inc[MOD_BITS-1:0];
               end
            end
         end
         default: state_in = FR_SYNC;
      endcase
      if (csr_we) begin
         state_in    = FR_SYNC;
         sync_cnt_in = SYNC_LAST;
         ph_in       = '0;
         offm_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FR_SYNC;
         sync_cnt_ff <= SYNC_LAST;
         sc_ff       <= RESET_SUBCARRIERS;
         sp_ff       <= RESET_PILOT_SPACING;
         dc_ff       <= RESET_DC_NULL_WIDTH;
         idx_ff      <= '0;
         ph_ff       <= '0;
         offm_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         sync_cnt_ff <= sync_cnt_in;
         sc_ff       <= sc_in;
         sp_ff       <= sp_in;
         dc_ff       <= dc_in;
         idx_ff      <= idx_in;
         ph_ff       <= ph_in;
         offm_ff     <= offm_in;
      end
   end

   // power stage
   assign b_valid_in = accept;
   always_ff @(posedge clock) begin
      if (accept) begin
         b_pilot_ff       <= pilot;
         b_kept_ff        <= lower || upper;
         b_last_ff        <= last;
         b_sqre_ff        <= sqre_s;
         b_sqim_ff        <= sqim_s;
         b_cfg_ff.spacing <= sp_ff;
         b_cfg_ff.count   <= count;
         b_cfg_ff.dc      <= dc_ff;
      end
   end

   assign pw = b_sqre_ff + b_sqim_ff;

   always_comb begin
      pilot_sum_in = pilot_sum_ff;
      null_sum_in  = null_sum_ff;
      if (b_valid_ff && b_kept_ff) begin
         if (b_pilot_ff) begin
            pilot_sum_in = pilot_sum_ff + SUM_BITS'(pw);
         end else begin
            null_sum_in = null_sum_ff + SUM_BITS'(pw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         pilot_sum_ff <= '0;
         null_sum_ff  <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (pend) begin
            pilot_sum_ff <= '0;
            null_sum_ff  <= '0;
         end else begin
            pilot_sum_ff <= pilot_sum_in;
            null_sum_ff  <= null_sum_in;
         end
      end
   end

   assign push        = pend;
   assign pilot_total = pilot_sum_in;
   assign null_total  = null_sum_in;
   assign push_cfg    = b_cfg_ff;
endmodule

// ===== sv/ospe_divider.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ospe_divider import ospe_pkg::*; #(
   parameter int NUM_BITS = 56,
   parameter int DEN_BITS = 51
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                busy,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(NUM_BITS);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS:0]   t, t2;
   logic                ge;

   assign t  = {rem_ff, num_ff[NUM_BITS-1]};
   assign ge = (t >= {1'b0, den_ff});
   assign t2 = ge ? (t - {1'b0, den_ff}) : t;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(NUM_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], ge};
         rem_in = t2[DEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = num_ff;
endmodule

// ===== sv/ospe_back.sv =====
// Back end: per vector noise and SNR computation and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ospe_back import ospe_pkg::*; #(
   parameter int SUM_BITS = 43,
   parameter int NUM_BITS = 56
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fifo_empty,
   input  logic [SUM_BITS-1:0] fifo_pilot,
   input  logic [SUM_BITS-1:0] fifo_null,
   input  vec_cfg_type         fifo_cfg,
   output logic                fifo_pop,
   ospe_rsp_if.source          rsp
);
   back_state_type            state_ff, state_in;
   logic [SUM_BITS-1:0]       pilot_ff, pilot_in, null_ff, null_in;
   vec_cfg_type               cfg_ff, cfg_in;
   logic [COUNT_BITS-1:0]     k_ff, k_in;
   logic [PROD_BITS-1:0]      prod_ff, prod_in;
   logic [NOISE_BITS-1:0]     noise_ff, noise_in, noise_sat;
   logic [PMEAN_BITS-1:0]     pm_ff, pm_in, pm_sat, mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [DIV_DEN_BITS-1:0]   den_ff, den_in;
   logic [SNR_BITS-1:0]       snr_ff, snr_in, snr_pos, snr_neg;
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic signed [PROD_BITS:0] d_s;
   logic                      d_ok, neg_big;
   logic                      div_start, div_busy, div_done;
   logic [NUM_BITS-1:0]       div_num, div_quot;
   logic [DIV_DEN_BITS-1:0]   div_den;

   ospe_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DIV_DEN_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign d_s  = signed'({1'b0, prod_ff}) - signed'({(PROD_BITS + 1 - CFG_DC_BITS)'(0), cfg_ff.dc});
   assign d_ok = !d_s[PROD_BITS] && (d_s != '0) && (k_ff != '0);

   assign noise_sat = (|div_quot[NUM_BITS-1:NOISE_BITS]) ? '1 : div_quot[NOISE_BITS-1:0];
   assign pm_sat    = (|div_quot[NUM_BITS-1:PMEAN_BITS]) ? '1 : div_quot[PMEAN_BITS-1:0];
   assign snr_pos   = (|div_quot[NUM_BITS-1:SNR_BITS-1]) ? SNR_MAX :
                      {1'b0, div_quot[SNR_BITS-2:0]};
   assign neg_big   = (|div_quot[NUM_BITS-1:SNR_BITS]) ||
                      (div_quot[SNR_BITS-1] && (|div_quot[SNR_BITS-2:0]));
   assign snr_neg   = neg_big ? SNR_MIN : (~div_quot[SNR_BITS-1:0] + 1'b1);

   always_comb begin
      state_in  = state_ff;
      pilot_in  = pilot_ff;
      null_in   = null_ff;
      cfg_in    = cfg_ff;
      k_in      = k_ff;
      prod_in   = prod_ff;
      noise_in  = noise_ff;
      pm_in     = pm_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      den_in    = den_ff;
      snr_in    = snr_ff;
      status_in = status_ff;
      fifo_pop  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               pilot_in = fifo_pilot;
               null_in  = fifo_null;
               cfg_in   = fifo_cfg;
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            if (cfg_ff.spacing == '0) begin
               status_in = ST_INVALID;
               snr_in    = '0;
               noise_in  = '0;
               state_in  = BK_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_BITS'(cfg_ff.count);
               div_den   = DIV_DEN_BITS'(cfg_ff.spacing);
               state_in  = BK_DIV_K;
            end
         end
         BK_DIV_K: begin
            if (div_done) begin
               k_in     = div_quot[COUNT_BITS-1:0];
               state_in = BK_MUL_D;
            end
         end
         BK_MUL_D: begin
            prod_in  = {(PROD_BITS - CFG_SP_BITS)'(0), cfg_ff.spacing - 1'b1} *
                       {(PROD_BITS - COUNT_BITS)'(0), k_ff};
            state_in = BK_CHK_D;
         end
         BK_CHK_D: begin
            if (!d_ok) begin
               status_in = ST_INVALID;
               snr_in    = '0;
               noise_in  = '0;
               state_in  = BK_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_BITS'({null_ff, 8'd0});
               div_den   = DIV_DEN_BITS'(d_s[PROD_BITS-1:0]);
               state_in  = BK_DIV_NOISE;
            end
         end
         BK_DIV_NOISE: begin
            if (div_done) begin
               noise_in = noise_sat;
               if (noise_sat == '0) begin
                  status_in = ST_NOISE_ZERO;
                  snr_in    = SNR_MAX;
                  state_in  = BK_OUT;
               end else begin
                  div_start = 1'b1;
                  div_num   = NUM_BITS'({pilot_ff, 8'd0});
                  div_den   = DIV_DEN_BITS'(k_ff);
                  state_in  = BK_DIV_PM;
               end
            end
         end
         BK_DIV_PM: begin
            if (div_done) begin
               pm_in    = pm_sat;
               state_in = BK_MUL_S;
            end
         end
         BK_MUL_S: begin
            den_in   = {(DIV_DEN_BITS - NOISE_BITS)'(0), noise_ff} *
                       {(DIV_DEN_BITS - CFG_SP_BITS)'(0), cfg_ff.spacing};
            neg_in   = pm_ff < {1'b0, noise_ff};
            mag_in   = (pm_ff < {1'b0, noise_ff}) ? ({1'b0, noise_ff} - pm_ff) :
                                                     (pm_ff - {1'b0, noise_ff});
            state_in = BK_SNR_START;
         end
         BK_SNR_START: begin
            div_start = 1'b1;
            div_num   = NUM_BITS'({mag_ff, 16'd0});
            div_den   = den_ff;
            state_in  = BK_DIV_SNR;
         end
         BK_DIV_SNR: begin
            if (div_done) begin
               snr_in    = neg_ff ? snr_neg : snr_pos;
               status_in = ST_VALID;
               state_in  = BK_OUT;
            end
         end
         BK_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pilot_ff  <= pilot_in;
      null_ff   <= null_in;
      cfg_ff    <= cfg_in;
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      noise_ff  <= noise_in;
      pm_ff     <= pm_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      den_ff    <= den_in;
      snr_ff    <= snr_in;
      status_ff <= status_in;
   end

   assign rsp.snr_ratio   = snr_ff;
   assign rsp.noise_power = noise_ff;
   assign rsp.status      = status_ff;

   `OSPE_ASSERT(a_div_start_idle, clock, reset, div_start |-> !div_busy, "divider restarted while busy")
   `OSPE_ASSERT(a_invalid_zero, clock, reset, (state_ff == BK_OUT && status_ff == ST_INVALID) |-> (snr_ff == '0 && noise_ff == '0), "invalid result not zeroed")
   `OSPE_ASSERT(a_noise_zero, clock, reset, (state_ff == BK_OUT && status_ff == ST_NOISE_ZERO) |-> (noise_ff == '0 && snr_ff == SNR_MAX), "noise zero result malformed")
   `OSPE_ASSERT_NEXT(a_snr_done, clock, reset, state_ff == BK_DIV_SNR && div_done, state_ff == BK_OUT && status_ff == ST_VALID, "SNR division did not complete to output")
endmodule
